/* hw/rtl/srrb_pkg.sv */
// Shared types, codes and defaults of the sequence reorder receive buffer.
package srrb_pkg;

  localparam int unsigned WINDOW_DEF      = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned ACTION_W = 8;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BURST_W  = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MORE_CODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND_BURST = 1'd1;

  localparam logic [ACTION_W-1:0] MORE_CODE_RESET = 8'd0;
  localparam logic [BURST_W-1:0]  BURST_RESET     = 4'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic clear_start;
    logic clear_step;
    logic set_req_en;
    logic store;
    logic rd_ne;
    logic deliver;
    logic srch_init;
    logic rd_scan;
    logic srch_next;
    logic req_init;
    logic req_emit;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_valid;
    logic clr_done;
    logic scan_end;
    logic req_done;
    logic out_free;
    logic req_en;
  } status_t;

endpackage

/* hw/rtl/seq_reorder_receive_buffer.sv */
// Top level of the sequence reorder receive buffer: controller plus datapath.
// A data packet is stored, delivers in order and, with requests enabled, searches the window
// and issues resend requests. Output stalls hold the controller. The window memory has one
// registered read port.
// After rst_ni, and after a buffer reset, a clearing sweep of the window runs with input stalled.
module seq_reorder_receive_buffer #(
  parameter int unsigned WINDOW      = srrb_pkg::WINDOW_DEF,
  parameter int unsigned HANDLE_BITS = srrb_pkg::HANDLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input transaction
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [srrb_pkg::OP_W-1:0]        op_i,
  input  logic [srrb_pkg::SEQ_W-1:0]       seq_i,
  input  logic [srrb_pkg::ACTION_W-1:0]    action_i,
  input  logic [srrb_pkg::HANDLE_W-1:0]    payload_handle_i,
  // result transaction
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [srrb_pkg::KIND_W-1:0]      kind_o,
  output logic [srrb_pkg::SEQ_W-1:0]       out_seq_o,
  output logic [srrb_pkg::ACTION_W-1:0]    out_action_o,
  output logic [srrb_pkg::HANDLE_W-1:0]    out_handle_o,
  output logic                             message_end_o,
  output logic                             last_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [srrb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srrb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  // The controller walks one packet at a time: store, deliver in order, search for
  // the first gap end, issue resend requests. The datapath holds each result in a
  // pending register until the next one appears, so the final one can carry last.
  srrb_pkg::cmd_t    cmd;
  srrb_pkg::status_t status;

  srrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srrb_dpath #(
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seq_i            (seq_i),
    .action_i         (action_i),
    .payload_handle_i (payload_handle_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .kind_o           (kind_o),
    .out_seq_o        (out_seq_o),
    .out_action_o     (out_action_o),
    .out_handle_o     (out_handle_o),
    .message_end_o    (message_end_o),
    .last_o           (last_o)
  );

`ifndef SYNTHESIS
  // A result is never pushed over one that is still stalled at the output.
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.deliver || cmd.req_emit || cmd.finish) |-> status.out_free)
    else $error("result pushed while output register is blocked");

  // Only one source writes the window memory in a cycle.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear_step, cmd.store, cmd.deliver}))
    else $error("conflicting window memory writes");

  // A data packet holds off the next transaction while it is processed.
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == srrb_pkg::OP_DATA) |=> in_stall_o)
    else $error("input taken while a data packet is in progress");

  // A buffer reset starts the clearing sweep with input stalled.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == srrb_pkg::OP_RESET) |=> in_stall_o)
    else $error("input taken during window clear");
`endif

endmodule

/* hw/rtl/srrb_ctrl.sv */
// Sequencing state machine of the sequence reorder receive buffer.
module srrb_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [srrb_pkg::OP_W-1:0]    op_i,
  output logic                         in_stall_o,
  input  srrb_pkg::status_t            status_i,
  output srrb_pkg::cmd_t               cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_STORE    = 9'b000000100,
    S_DLV_RD   = 9'b000001000,
    S_DLV_CHK  = 9'b000010000,
    S_SRCH_RD  = 9'b000100000,
    S_SRCH_CHK = 9'b001000000,
    S_REQ      = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            srrb_pkg::OP_DATA: begin
              cmd_o.latch_in = 1'b1;
              state_d        = S_STORE;
            end
            srrb_pkg::OP_TICK:  cmd_o.set_req_en = 1'b1;
            srrb_pkg::OP_RESET: begin
              cmd_o.clear_start = 1'b1;
              state_d           = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_DLV_RD;
      end
      S_DLV_RD: begin
        cmd_o.rd_ne = 1'b1;
        state_d     = S_DLV_CHK;
      end
      S_DLV_CHK: begin
        if (status_i.rd_valid) begin
          if (status_i.out_free) begin
            cmd_o.deliver = 1'b1;
            state_d       = S_DLV_RD;
          end
        end else if (status_i.req_en) begin
          cmd_o.srch_init = 1'b1;
          state_d         = S_SRCH_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SRCH_RD: begin
        if (status_i.scan_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (status_i.rd_valid) begin
          cmd_o.req_init = 1'b1;
          state_d        = S_REQ;
        end else begin
          cmd_o.srch_next = 1'b1;
          state_d         = S_SRCH_RD;
        end
      end
      S_REQ: begin
        if (status_i.req_done) begin
          state_d = S_FIN;
        end else if (status_i.out_free) begin
          cmd_o.req_emit = 1'b1;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/srrb_dpath.sv */
// Datapath of the sequence reorder receive buffer: window memory, counters, result registers.
module srrb_dpath #(
  parameter int unsigned WINDOW      = srrb_pkg::WINDOW_DEF,
  parameter int unsigned HANDLE_BITS = srrb_pkg::HANDLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [srrb_pkg::SEQ_W-1:0]         seq_i,
  input  logic [srrb_pkg::ACTION_W-1:0]      action_i,
  input  logic [srrb_pkg::HANDLE_W-1:0]      payload_handle_i,
  input  logic                               cfg_we_i,
  input  logic [srrb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [srrb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  srrb_pkg::cmd_t                     cmd_i,
  output srrb_pkg::status_t                  status_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [srrb_pkg::KIND_W-1:0]        kind_o,
  output logic [srrb_pkg::SEQ_W-1:0]         out_seq_o,
  output logic [srrb_pkg::ACTION_W-1:0]      out_action_o,
  output logic [srrb_pkg::HANDLE_W-1:0]      out_handle_o,
  output logic                               message_end_o,
  output logic                               last_o
);

  localparam int unsigned IdxW = $clog2(WINDOW);
  localparam int unsigned KW   = $clog2(WINDOW + 1);
  localparam int unsigned HW   = (HANDLE_BITS < srrb_pkg::HANDLE_W) ? HANDLE_BITS
                                                                     : srrb_pkg::HANDLE_W;
  localparam int unsigned EntW = 1 + srrb_pkg::ACTION_W + HW;
  localparam int unsigned SW   = srrb_pkg::SEQ_W;
  localparam int unsigned AW   = srrb_pkg::ACTION_W;
  localparam int unsigned BW   = srrb_pkg::BURST_W;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW - 1);
  localparam logic [IdxW:0]   WinIdx  = (IdxW + 1)'(WINDOW);
  localparam logic [KW-1:0]   WinK    = KW'(WINDOW);

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] x);
    return (x == LastIdx) ? '0 : x + 1'b1;
  endfunction

  // configuration
  logic [AW-1:0] more_code_q;
  logic [BW-1:0] burst_q;

  // control state
  logic [SW-1:0]   ne_q;
  logic [IdxW-1:0] ne_idx_q;
  logic            req_en_q;
  logic [IdxW-1:0] clr_q;
  logic            out_valid_q;

  // working registers
  logic [SW-1:0]   s_q;
  logic [AW-1:0]   act_q;
  logic [HW-1:0]   hdl_q;
  logic [KW-1:0]   k_q;
  logic [SW-1:0]   scan_seq_q;
  logic [IdxW-1:0] scan_idx_q;
  logic [BW-1:0]   lim_q;
  logic [BW-1:0]   j_q;

  // pending result, held until the next one tells whether it is the last
  logic [srrb_pkg::KIND_W-1:0] pend_kind_q;
  logic [SW-1:0]               pend_seq_q;
  logic [AW-1:0]               pend_act_q;
  logic [HW-1:0]               pend_hdl_q;
  logic                        pend_end_q;

  logic [srrb_pkg::KIND_W-1:0] out_kind_q;
  logic [SW-1:0]               out_seq_q;
  logic [AW-1:0]               out_act_q;
  logic [HW-1:0]               out_hdl_q;
  logic                        out_end_q;
  logic                        out_last_q;

  // window memory
  logic [EntW-1:0] mem_q [WINDOW];
  logic [EntW-1:0] rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [EntW-1:0] mem_wdata;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  // classification of the latched packet
  logic [SW:0]     diff;
  logic            below;
  logic            in_win;
  logic [IdxW:0]   st_sum;
  logic [IdxW-1:0] st_idx;
  logic            out_load;
  logic            out_free;
  logic [AW-1:0]   rd_act;
  logic [HW-1:0]   rd_hdl;

  assign diff   = {1'b0, s_q} - {1'b0, ne_q};
  assign below  = (s_q < ne_q);
  assign in_win = !below && (diff < (SW + 1)'(WINDOW));
  assign st_sum = {1'b0, ne_idx_q} + {1'b0, diff[IdxW-1:0]};
  assign st_idx = (st_sum >= WinIdx) ? IdxW'(st_sum - WinIdx) : st_sum[IdxW-1:0];

  assign rd_act = rd_q[AW+HW-1:HW];
  assign rd_hdl = rd_q[HW-1:0];

  assign out_load = cmd_i.deliver | cmd_i.req_emit | cmd_i.finish;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ne_idx_q;
    mem_wdata = '0;
    if (cmd_i.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (cmd_i.store) begin
      mem_we    = in_win;
      mem_waddr = st_idx;
      mem_wdata = {1'b1, act_q, hdl_q};
    end else if (cmd_i.deliver) begin
      mem_we    = 1'b1;
    end
  end

  assign rd_en   = cmd_i.rd_ne | cmd_i.rd_scan;
  assign rd_addr = cmd_i.rd_scan ? scan_idx_q : ne_idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      more_code_q <= srrb_pkg::MORE_CODE_RESET;
      burst_q     <= srrb_pkg::BURST_RESET;
      ne_q        <= SW'(1);
      ne_idx_q    <= IdxW'(1);
      req_en_q    <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srrb_pkg::REG_MORE_CODE:    more_code_q <= cfg_wdata_i;
          srrb_pkg::REG_RESEND_BURST: burst_q     <= cfg_wdata_i[BW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear_start) begin
        ne_q     <= SW'(1);
        ne_idx_q <= IdxW'(1);
        clr_q    <= '0;
      end
      if (cmd_i.clear_step) clr_q <= idx_inc(clr_q);
      if (cmd_i.deliver) begin
        ne_q     <= ne_q + 1'b1;
        ne_idx_q <= (ne_q == '1) ? '0 : idx_inc(ne_idx_q);
      end
      if (cmd_i.set_req_en || cmd_i.deliver) req_en_q <= 1'b1;
      else if (cmd_i.req_init)               req_en_q <= 1'b0;
      if (out_load)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      s_q   <= seq_i;
      act_q <= action_i;
      hdl_q <= payload_handle_i[HW-1:0];
    end
    if (cmd_i.srch_init) begin
      k_q        <= KW'(1);
      scan_seq_q <= ne_q + 1'b1;
      scan_idx_q <= idx_inc(ne_idx_q);
    end else if (cmd_i.srch_next) begin
      k_q        <= k_q + 1'b1;
      scan_seq_q <= scan_seq_q + 1'b1;
      scan_idx_q <= idx_inc(scan_idx_q);
    end
    if (cmd_i.req_init) begin
      lim_q <= (32'(k_q) < 32'(burst_q)) ? BW'(k_q) : burst_q;
      j_q   <= '0;
    end else if (cmd_i.req_emit) begin
      j_q <= j_q + 1'b1;
    end
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_seq_q  <= pend_seq_q;
      out_act_q  <= pend_act_q;
      out_hdl_q  <= pend_hdl_q;
      out_end_q  <= pend_end_q;
      out_last_q <= cmd_i.finish;
    end
    if (cmd_i.store) begin
      pend_kind_q <= (below || in_win) ? srrb_pkg::KIND_ACK : srrb_pkg::KIND_DROP;
      pend_seq_q  <= s_q;
      pend_act_q  <= '0;
      pend_hdl_q  <= '0;
      pend_end_q  <= 1'b0;
    end else if (cmd_i.deliver) begin
      pend_kind_q <= srrb_pkg::KIND_DELIVER;
      pend_seq_q  <= ne_q;
      pend_act_q  <= rd_act;
      pend_hdl_q  <= rd_hdl;
      pend_end_q  <= (rd_act != more_code_q);
    end else if (cmd_i.req_emit) begin
      pend_kind_q <= srrb_pkg::KIND_REQUEST;
      pend_seq_q  <= ne_q + SW'(j_q);
      pend_act_q  <= '0;
      pend_hdl_q  <= '0;
      pend_end_q  <= 1'b0;
    end
  end

  assign status_o.rd_valid = rd_q[EntW-1];
  assign status_o.clr_done = (clr_q == LastIdx);
  assign status_o.scan_end = (k_q == WinK) || (scan_seq_q == '0);
  assign status_o.req_done = (j_q == lim_q);
  assign status_o.out_free = out_free;
  assign status_o.req_en   = req_en_q;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign out_seq_o     = out_seq_q;
  assign out_action_o  = out_act_q;
  assign out_handle_o  = srrb_pkg::HANDLE_W'(out_hdl_q);
  assign message_end_o = out_end_q;
  assign last_o        = out_last_q;

endmodule
